/* src/kf6_pkg.sv */
// ----------------------------------------------------------------------------
// kf6_pkg
// Shared types, codes and fixed-point helpers for the 6-state Kalman filter.
// ----------------------------------------------------------------------------
package kf6_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int MAG_W  = WORD_W + FRAC_W;

    localparam logic [WORD_W-1:0] FX_ONE  = WORD_W'(1) << FRAC_W;
    localparam logic [WORD_W-1:0] FX_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] FX_MIN  = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic [1:0] MODE_INIT    = 2'd0;
    localparam logic [1:0] MODE_PREDICT = 2'd1;
    localparam logic [1:0] MODE_UPDATE  = 2'd2;

    localparam logic CFG_PROCESS_NOISE     = 1'b0;
    localparam logic CFG_MEASUREMENT_NOISE = 1'b1;

    localparam logic [30:0] PROCESS_NOISE_RST     = 31'd655;
    localparam logic [30:0] MEASUREMENT_NOISE_RST = 31'd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ADD,
        ST_DIV
    } state_t;

    typedef enum logic [4:0] {
        PH_INIT,
        PH_PR_T,
        PH_PR_C,
        PH_PR_Q,
        PH_PR_X,
        PH_UP_S,
        PH_UP_COF,
        PH_UP_DET,
        PH_UP_INV,
        PH_UP_K,
        PH_UP_Y,
        PH_UP_KY,
        PH_UP_X,
        PH_UP_IKH,
        PH_UP_NP,
        PH_UP_CP,
        PH_OUT
    } phase_t;

    typedef enum logic [3:0] {
        OPS_ZERO,
        OPS_ONE,
        OPS_DT,
        OPS_Q,
        OPS_R,
        OPS_IN,
        OPS_RD0,
        OPS_RD1,
        OPS_ACC
    } opsel_t;

    typedef struct packed {
        logic [7:0] addr0;
        logic [7:0] addr1;
        logic [7:0] waddr;
        opsel_t     a_sel;
        opsel_t     b_sel;
        opsel_t     c_sel;
        logic       sub;
        logic       wr;
        logic [2:0] in_idx;
        logic [2:0] ni;
        logic [2:0] nj;
        logic [2:0] nk;
    } ctl_t;

    function automatic logic [WORD_W-1:0] fx_mag(input logic [WORD_W-1:0] v);
        fx_mag = v[WORD_W-1] ? (WORD_W'(0) - v) : v;
    endfunction

    function automatic logic [WORD_W-1:0] fx_from_mag(input logic [MAG_W-1:0] m,
                                                      input logic neg);
        if (neg) begin
            if (m > MAG_W'(FX_MIN)) begin
                fx_from_mag = FX_MIN;
            end else begin
                fx_from_mag = WORD_W'(0) - m[WORD_W-1:0];
            end
        end else begin
            if (m > MAG_W'(FX_MAX)) begin
                fx_from_mag = FX_MAX;
            end else begin
                fx_from_mag = m[WORD_W-1:0];
            end
        end
    endfunction

    function automatic logic [WORD_W-1:0] fx_sat(input logic [WORD_W:0] s);
        if (s[WORD_W] != s[WORD_W-1]) begin
            fx_sat = s[WORD_W] ? FX_MIN : FX_MAX;
        end else begin
            fx_sat = s[WORD_W-1:0];
        end
    endfunction

endpackage

/* src/kf6_div.sv */
// ----------------------------------------------------------------------------
// kf6_div
// Radix-2 restoring fixed-point divider: saturated (n << FRAC) / d, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module kf6_div import kf6_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] num,
    input  logic [WORD_W-1:0] den,
    output logic              done,
    output logic [WORD_W-1:0] quo
);

    localparam int DIV_STEPS = MAG_W;

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic [MAG_W-1:0]  dvd_reg;
    logic [MAG_W-1:0]  quo_reg;
    logic [WORD_W:0]   rem_reg;
    logic [WORD_W-1:0] den_reg;
    logic              neg_reg;

    logic [WORD_W:0]   rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg[WORD_W-1:0], dvd_reg[MAG_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 6'(DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            dvd_reg <= {fx_mag(num), FRAC_W'(0)};
            quo_reg <= '0;
            rem_reg <= '0;
            den_reg <= fx_mag(den);
            neg_reg <= num[WORD_W-1] ^ den[WORD_W-1];
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 6'd1;
            dvd_reg <= {dvd_reg[MAG_W-2:0], 1'b0};
            quo_reg <= {quo_reg[MAG_W-2:0], fits};
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        end
    end

    assign done = done_reg;
    assign quo  = fx_from_mag(quo_reg, neg_reg);

endmodule

/* src/kalman_filter_6state_cv_unit.sv */
// ----------------------------------------------------------------------------
// kalman_filter_6state_cv_unit
// Constant-velocity Kalman filter over three axes, Q16.16, run on one shared
// saturating multiply-accumulate unit and one iterative divider.
// ----------------------------------------------------------------------------
// One item is taken at a time; s_tready is high only while the sequencer is
// idle. A micro-step is a read, a multiply and a saturating add on the shared
// unit (the inverse steps divide instead of adding, and the read-back steps do
// not add), over a 256-word scratch memory that holds covariance, state and
// temporaries. A predict runs 81 steps, and an update runs its MAC steps plus
// nine divisions for the 3x3 inverse; a singular innovation ends the update
// early. The six results are read back at the end, waiting while an earlier result is untaken.
// The next item may be accepted while a finished result waits on m_tready.
module kalman_filter_6state_cv_unit import kf6_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // time_step[15:0], pos_x_in, pos_y_in, pos_z_in, vel_x_in, vel_y_in, vel_z_in
    input  logic [207:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x_est, pos_y_est, pos_z_est, vel_x_est, vel_y_est, vel_z_est
    output logic [191:0] m_tdata,
    // gain_fault
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [30:0]  cfg_data
);

    localparam logic [7:0] P_BASE   = 8'd0;
    localparam logic [7:0] X_BASE   = 8'd36;
    localparam logic [7:0] T_BASE   = 8'd42;
    localparam logic [7:0] S_BASE   = 8'd78;
    localparam logic [7:0] COF_BASE = 8'd87;
    localparam logic [7:0] INV_BASE = 8'd96;
    localparam logic [7:0] K_BASE   = 8'd105;
    localparam logic [7:0] Y_BASE   = 8'd123;
    localparam logic [7:0] KY_BASE  = 8'd126;
    localparam logic [7:0] IKH_BASE = 8'd132;
    localparam int         VLD_N    = 42;
    localparam int         MEM_N    = 256;

    state_t st_reg, st_next;
    phase_t phase_reg, phase_next;
    ctl_t   ctl;

    logic [2:0]  i_reg, j_reg, k_reg;
    logic [1:0]  mode_reg;
    logic [15:0] dt_reg;
    logic [WORD_W-1:0] in_reg [6];
    logic [30:0] q_reg, r_reg;
    logic        fault_reg;

    logic [WORD_W-1:0] mem [MEM_N];
    logic [WORD_W-1:0] rd0_reg, rd1_reg;
    logic              rd0_dflt_reg, rd1_dflt_reg, rd0_one_reg, rd1_one_reg;
    logic [VLD_N-1:0]  valid_reg;
    logic [WORD_W-1:0] rd0, rd1;

    logic [2*WORD_W-1:0] prod_reg;
    logic                neg_reg;
    logic [WORD_W-1:0]   a_reg;
    logic                sub_reg;
    logic [WORD_W-1:0]   acc_reg;
    logic [WORD_W-1:0]   a_val, b_val, c_val, in_val, fm, res;

    logic [WORD_W-1:0] out_reg [6];
    logic              m_tvalid_reg, m_fault_reg;

    logic i_last, j_last, k_last, all_last;
    logic step_done, mem_we, div_start, det_zero, accept;
    logic [WORD_W-1:0] mem_wdata;
    logic              div_done;
    logic [WORD_W-1:0] div_quo;

    function automatic logic [7:0] idx6(input logic [2:0] r, input logic [2:0] c);
        idx6 = {5'b0, r} * 8'd6 + {5'b0, c};
    endfunction

    function automatic logic [7:0] idx3(input logic [2:0] r, input logic [2:0] c);
        idx3 = {5'b0, r} * 8'd3 + {5'b0, c};
    endfunction

    function automatic logic is_diag(input logic [7:0] a);
        is_diag = a == 8'd0 || a == 8'd7 || a == 8'd14 || a == 8'd21 ||
                  a == 8'd28 || a == 8'd35;
    endfunction

    function automatic logic [WORD_W-1:0] op_val(input opsel_t sel,
                                                 input logic [WORD_W-1:0] r0,
                                                 input logic [WORD_W-1:0] r1,
                                                 input logic [WORD_W-1:0] acc,
                                                 input logic [WORD_W-1:0] inw,
                                                 input logic [15:0] dt,
                                                 input logic [30:0] q,
                                                 input logic [30:0] r);
        case (sel)
            OPS_ZERO: op_val = '0;
            OPS_ONE:  op_val = FX_ONE;
            OPS_DT:   op_val = {16'b0, dt};
            OPS_Q:    op_val = {1'b0, q};
            OPS_R:    op_val = {1'b0, r};
            OPS_IN:   op_val = inw;
            OPS_RD0:  op_val = r0;
            OPS_RD1:  op_val = r1;
            OPS_ACC:  op_val = acc;
            default:  op_val = '0;
        endcase
    endfunction

    // micro-step decode
    always_comb begin
        logic [2:0] r0, r1, c0, c1;
        logic       odd;
        r0  = (i_reg == 3'd0) ? 3'd1 : 3'd0;
        r1  = (i_reg == 3'd2) ? 3'd1 : 3'd2;
        c0  = (j_reg == 3'd0) ? 3'd1 : 3'd0;
        c1  = (j_reg == 3'd2) ? 3'd1 : 3'd2;
        odd = i_reg[0] ^ j_reg[0];
        ctl        = '0;
        ctl.a_sel  = OPS_ZERO;
        ctl.b_sel  = OPS_ZERO;
        ctl.c_sel  = OPS_ONE;
        ctl.in_idx = i_reg;
        case (phase_reg)
            PH_INIT: begin
                ctl.ni = 3'd5;
                ctl.b_sel = OPS_ONE;
                ctl.c_sel = OPS_IN;
                ctl.wr = 1'b1;
                ctl.waddr = X_BASE + {5'b0, i_reg};
            end
            PH_PR_T: begin
                ctl.ni = 3'd5;
                ctl.nj = 3'd5;
                ctl.addr0 = P_BASE + idx6(i_reg, j_reg);
                ctl.addr1 = P_BASE + idx6(i_reg + 3'd3, j_reg);
                ctl.a_sel = OPS_RD0;
                if (i_reg < 3'd3) begin
                    ctl.b_sel = OPS_DT;
                    ctl.c_sel = OPS_RD1;
                end
                ctl.wr = 1'b1;
                ctl.waddr = T_BASE + idx6(i_reg, j_reg);
            end
            PH_PR_C: begin
                ctl.ni = 3'd5;
                ctl.nj = 3'd5;
                ctl.addr0 = T_BASE + idx6(i_reg, j_reg);
                ctl.addr1 = T_BASE + idx6(i_reg, j_reg + 3'd3);
                ctl.a_sel = OPS_RD0;
                if (j_reg < 3'd3) begin
                    ctl.b_sel = OPS_DT;
                    ctl.c_sel = OPS_RD1;
                end
                ctl.wr = 1'b1;
                ctl.waddr = P_BASE + idx6(i_reg, j_reg);
            end
            PH_PR_Q: begin
                ctl.ni = 3'd5;
                ctl.addr0 = P_BASE + idx6(i_reg, i_reg);
                ctl.a_sel = OPS_RD0;
                ctl.b_sel = OPS_ONE;
                ctl.c_sel = OPS_Q;
                ctl.wr = 1'b1;
                ctl.waddr = P_BASE + idx6(i_reg, i_reg);
            end
            PH_PR_X: begin
                ctl.ni = 3'd2;
                ctl.addr0 = X_BASE + {5'b0, i_reg};
                ctl.addr1 = X_BASE + {5'b0, i_reg} + 8'd3;
                ctl.a_sel = OPS_RD0;
                ctl.b_sel = OPS_DT;
                ctl.c_sel = OPS_RD1;
                ctl.wr = 1'b1;
                ctl.waddr = X_BASE + {5'b0, i_reg};
            end
            PH_UP_S: begin
                ctl.ni = 3'd2;
                ctl.nj = 3'd2;
                ctl.addr0 = P_BASE + idx6(i_reg + 3'd3, j_reg + 3'd3);
                ctl.a_sel = OPS_RD0;
                if (i_reg == j_reg) begin
                    ctl.b_sel = OPS_ONE;
                    ctl.c_sel = OPS_R;
                end
                ctl.wr = 1'b1;
                ctl.waddr = S_BASE + idx3(i_reg, j_reg);
            end
            PH_UP_COF: begin
                ctl.ni = 3'd2;
                ctl.nj = 3'd2;
                ctl.nk = 3'd2;
                ctl.wr = 1'b1;
                ctl.waddr = COF_BASE + idx3(i_reg, j_reg);
                case (k_reg)
                    3'd0: begin
                        ctl.addr0 = S_BASE + idx3(r0, c0);
                        ctl.addr1 = S_BASE + idx3(r1, c1);
                        ctl.b_sel = OPS_RD0;
                        ctl.c_sel = OPS_RD1;
                    end
                    3'd1: begin
                        ctl.addr0 = S_BASE + idx3(r0, c1);
                        ctl.addr1 = S_BASE + idx3(r1, c0);
                        ctl.a_sel = OPS_ACC;
                        ctl.b_sel = OPS_RD0;
                        ctl.c_sel = OPS_RD1;
                        ctl.sub = 1'b1;
                    end
                    default: begin
                        ctl.a_sel = odd ? OPS_ZERO : OPS_ACC;
                        ctl.b_sel = OPS_ONE;
                        ctl.c_sel = odd ? OPS_ACC : OPS_ZERO;
                        ctl.sub = odd;
                    end
                endcase
            end
            PH_UP_DET: begin
                ctl.nk = 3'd2;
                ctl.addr0 = S_BASE + {5'b0, k_reg};
                ctl.addr1 = COF_BASE + {5'b0, k_reg};
                ctl.a_sel = (k_reg == 3'd0) ? OPS_ZERO : OPS_ACC;
                ctl.b_sel = OPS_RD0;
                ctl.c_sel = OPS_RD1;
            end
            PH_UP_INV: begin
                ctl.ni = 3'd2;
                ctl.nj = 3'd2;
                ctl.addr0 = COF_BASE + idx3(j_reg, i_reg);
                ctl.wr = 1'b1;
                ctl.waddr = INV_BASE + idx3(i_reg, j_reg);
            end
            PH_UP_K: begin
                ctl.ni = 3'd5;
                ctl.nj = 3'd2;
                ctl.nk = 3'd2;
                ctl.addr0 = P_BASE + idx6(i_reg, k_reg + 3'd3);
                ctl.addr1 = INV_BASE + idx3(k_reg, j_reg);
                ctl.a_sel = (k_reg == 3'd0) ? OPS_ZERO : OPS_ACC;
                ctl.b_sel = OPS_RD0;
                ctl.c_sel = OPS_RD1;
                ctl.wr = 1'b1;
                ctl.waddr = K_BASE + idx3(i_reg, j_reg);
            end
            PH_UP_Y: begin
                ctl.ni = 3'd2;
                ctl.addr0 = X_BASE + {5'b0, i_reg} + 8'd3;
                ctl.a_sel = OPS_IN;
                ctl.in_idx = i_reg + 3'd3;
                ctl.b_sel = OPS_ONE;
                ctl.c_sel = OPS_RD0;
                ctl.sub = 1'b1;
                ctl.wr = 1'b1;
                ctl.waddr = Y_BASE + {5'b0, i_reg};
            end
            PH_UP_KY: begin
                ctl.ni = 3'd5;
                ctl.nk = 3'd2;
                ctl.addr0 = K_BASE + idx3(i_reg, k_reg);
                ctl.addr1 = Y_BASE + {5'b0, k_reg};
                ctl.a_sel = (k_reg == 3'd0) ? OPS_ZERO : OPS_ACC;
                ctl.b_sel = OPS_RD0;
                ctl.c_sel = OPS_RD1;
                ctl.wr = 1'b1;
                ctl.waddr = KY_BASE + {5'b0, i_reg};
            end
            PH_UP_X: begin
                ctl.ni = 3'd5;
                ctl.addr0 = X_BASE + {5'b0, i_reg};
                ctl.addr1 = KY_BASE + {5'b0, i_reg};
                ctl.a_sel = OPS_RD0;
                ctl.b_sel = OPS_ONE;
                ctl.c_sel = OPS_RD1;
                ctl.wr = 1'b1;
                ctl.waddr = X_BASE + {5'b0, i_reg};
            end
            PH_UP_IKH: begin
                ctl.ni = 3'd5;
                ctl.nj = 3'd5;
                ctl.addr1 = K_BASE + idx3(i_reg, j_reg - 3'd3);
                ctl.a_sel = (i_reg == j_reg) ? OPS_ONE : OPS_ZERO;
                if (j_reg >= 3'd3) begin
                    ctl.b_sel = OPS_ONE;
                    ctl.c_sel = OPS_RD1;
                end
                ctl.sub = 1'b1;
                ctl.wr = 1'b1;
                ctl.waddr = IKH_BASE + idx6(i_reg, j_reg);
            end
            PH_UP_NP: begin
                ctl.ni = 3'd5;
                ctl.nj = 3'd5;
                ctl.nk = 3'd5;
                ctl.addr0 = IKH_BASE + idx6(i_reg, k_reg);
                ctl.addr1 = P_BASE + idx6(k_reg, j_reg);
                ctl.a_sel = (k_reg == 3'd0) ? OPS_ZERO : OPS_ACC;
                ctl.b_sel = OPS_RD0;
                ctl.c_sel = OPS_RD1;
                ctl.wr = 1'b1;
                ctl.waddr = T_BASE + idx6(i_reg, j_reg);
            end
            PH_UP_CP: begin
                ctl.ni = 3'd5;
                ctl.nj = 3'd5;
                ctl.addr0 = T_BASE + idx6(i_reg, j_reg);
                ctl.a_sel = OPS_RD0;
                ctl.wr = 1'b1;
                ctl.waddr = P_BASE + idx6(i_reg, j_reg);
            end
            PH_OUT: begin
                ctl.ni = 3'd5;
                ctl.addr0 = X_BASE + {5'b0, i_reg};
            end
            default: begin
                ctl.ni = 3'd0;
            end
        endcase
    end

    assign i_last   = i_reg == ctl.ni;
    assign j_last   = j_reg == ctl.nj;
    assign k_last   = k_reg == ctl.nk;
    assign all_last = i_last && j_last && k_last;

    // scratch memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ctl.waddr] <= mem_wdata;
        end
        rd0_reg <= mem[ctl.addr0];
        rd1_reg <= mem[ctl.addr1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we && ctl.waddr < 8'(VLD_N)) begin
            valid_reg[ctl.waddr[5:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rd0_dflt_reg <= (ctl.addr0 < 8'(VLD_N)) ? !valid_reg[ctl.addr0[5:0]] : 1'b0;
        rd1_dflt_reg <= (ctl.addr1 < 8'(VLD_N)) ? !valid_reg[ctl.addr1[5:0]] : 1'b0;
        rd0_one_reg  <= is_diag(ctl.addr0);
        rd1_one_reg  <= is_diag(ctl.addr1);
    end

    assign rd0 = rd0_dflt_reg ? (rd0_one_reg ? FX_ONE : '0) : rd0_reg;
    assign rd1 = rd1_dflt_reg ? (rd1_one_reg ? FX_ONE : '0) : rd1_reg;

    // shared multiply-accumulate unit
    assign in_val = in_reg[ctl.in_idx];
    assign a_val  = op_val(ctl.a_sel, rd0, rd1, acc_reg, in_val, dt_reg, q_reg, r_reg);
    assign b_val  = op_val(ctl.b_sel, rd0, rd1, acc_reg, in_val, dt_reg, q_reg, r_reg);
    assign c_val  = op_val(ctl.c_sel, rd0, rd1, acc_reg, in_val, dt_reg, q_reg, r_reg);

    always_ff @(posedge aclk) begin
        if (st_reg == ST_MUL) begin
            prod_reg <= fx_mag(b_val) * fx_mag(c_val);
            neg_reg  <= b_val[WORD_W-1] ^ c_val[WORD_W-1];
            a_reg    <= a_val;
            sub_reg  <= ctl.sub;
        end
        if (st_reg == ST_ADD) begin
            acc_reg <= res;
        end
    end

    assign fm  = fx_from_mag(prod_reg[2*WORD_W-1:FRAC_W], neg_reg);
    assign res = sub_reg ? fx_sat({a_reg[WORD_W-1], a_reg} - {fm[WORD_W-1], fm})
                         : fx_sat({a_reg[WORD_W-1], a_reg} + {fm[WORD_W-1], fm});

    kf6_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (rd0),
        .den     (acc_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    st_next = ST_READ;
                end
            end
            ST_READ: begin
                if (!(phase_reg == PH_OUT && m_tvalid_reg)) begin
                    st_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (phase_reg == PH_UP_INV) begin
                    st_next = ST_DIV;
                end else if (phase_reg == PH_OUT) begin
                    st_next = all_last ? ST_IDLE : ST_READ;
                end else begin
                    st_next = ST_ADD;
                end
            end
            ST_ADD: begin
                st_next = ST_READ;
            end
            ST_DIV: begin
                if (div_done) begin
                    st_next = ST_READ;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // outputs and strobes
    always_comb begin
        s_tready  = st_reg == ST_IDLE;
        step_done = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = res;
        div_start = 1'b0;
        case (st_reg)
            ST_MUL: begin
                div_start = phase_reg == PH_UP_INV;
                step_done = phase_reg == PH_OUT;
            end
            ST_ADD: begin
                step_done = 1'b1;
                mem_we    = ctl.wr && k_last;
            end
            ST_DIV: begin
                step_done = div_done;
                mem_we    = div_done;
                mem_wdata = div_quo;
            end
            default: begin
                step_done = 1'b0;
            end
        endcase
    end

    assign accept   = s_tvalid && s_tready;
    assign det_zero = phase_reg == PH_UP_DET && res == '0;

    always_comb begin
        phase_next = PH_OUT;
        case (phase_reg)
            PH_PR_T:   phase_next = PH_PR_C;
            PH_PR_C:   phase_next = PH_PR_Q;
            PH_PR_Q:   phase_next = PH_PR_X;
            PH_UP_S:   phase_next = PH_UP_COF;
            PH_UP_COF: phase_next = PH_UP_DET;
            PH_UP_DET: phase_next = det_zero ? PH_OUT : PH_UP_INV;
            PH_UP_INV: phase_next = PH_UP_K;
            PH_UP_K:   phase_next = PH_UP_Y;
            PH_UP_Y:   phase_next = PH_UP_KY;
            PH_UP_KY:  phase_next = PH_UP_X;
            PH_UP_X:   phase_next = PH_UP_IKH;
            PH_UP_IKH: phase_next = PH_UP_NP;
            PH_UP_NP:  phase_next = PH_UP_CP;
            default:   phase_next = PH_OUT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            phase_reg <= PH_OUT;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            fault_reg <= 1'b0;
            mode_reg  <= MODE_INIT;
        end else begin
            st_reg <= st_next;
            if (accept) begin
                i_reg     <= '0;
                j_reg     <= '0;
                k_reg     <= '0;
                fault_reg <= 1'b0;
                mode_reg  <= s_tuser;
                case (s_tuser)
                    MODE_INIT:    phase_reg <= PH_INIT;
                    MODE_PREDICT: phase_reg <= PH_PR_T;
                    MODE_UPDATE:  phase_reg <= PH_UP_S;
                    default:      phase_reg <= PH_OUT;
                endcase
            end else if (step_done) begin
                if (!k_last) begin
                    k_reg <= k_reg + 3'd1;
                end else begin
                    k_reg <= '0;
                    if (!j_last) begin
                        j_reg <= j_reg + 3'd1;
                    end else begin
                        j_reg <= '0;
                        if (!i_last) begin
                            i_reg <= i_reg + 3'd1;
                        end else begin
                            i_reg     <= '0;
                            phase_reg <= phase_next;
                            if (det_zero) begin
                                fault_reg <= 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dt_reg    <= s_tdata[15:0];
            in_reg[0] <= s_tdata[47:16];
            in_reg[1] <= s_tdata[79:48];
            in_reg[2] <= s_tdata[111:80];
            in_reg[3] <= s_tdata[143:112];
            in_reg[4] <= s_tdata[175:144];
            in_reg[5] <= s_tdata[207:176];
        end
    end

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= PROCESS_NOISE_RST;
            r_reg <= MEASUREMENT_NOISE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PROCESS_NOISE:     q_reg <= cfg_data;
                CFG_MEASUREMENT_NOISE: r_reg <= cfg_data;
                default:               q_reg <= q_reg;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (st_reg == ST_MUL && phase_reg == PH_OUT) begin
            out_reg[i_reg] <= rd0;
            m_fault_reg    <= fault_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (st_reg == ST_MUL && phase_reg == PH_OUT && all_last) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg[5], out_reg[4], out_reg[3],
                       out_reg[2], out_reg[1], out_reg[0]};
    assign m_tuser  = m_fault_reg;

    a_div_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_DIV |-> phase_reg == PH_UP_INV)
        else $error("divider running outside the inverse phase");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_MUL && phase_reg == PH_OUT) |-> !m_tvalid_reg)
        else $error("result register overwritten before transfer");

    a_fault_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_IDLE && fault_reg) |-> mode_reg == MODE_UPDATE)
        else $error("gain fault raised outside an update");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg != ST_IDLE |-> (i_reg <= ctl.ni && j_reg <= ctl.nj && k_reg <= ctl.nk))
        else $error("loop counter beyond phase limit");

endmodule
